### src/iurf_pkg.sv
package iurf_pkg;

  localparam logic [7:0] IHL_MASK   = 8'h0F;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam int unsigned MIN_HEADER = 20;
  localparam int unsigned UDP_HEADER = 8;

  localparam logic [7:0] CFG_EXPECTED_SOURCE_PORT = 8'd0;
  localparam logic [7:0] CFG_EXPECTED_DEST_PORT   = 8'd1;

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED  = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_BAD_IHL   = 3'd2,
    VERDICT_NOT_UDP   = 3'd3,
    VERDICT_PORT_MISS = 3'd4,
    VERDICT_TRUNCATED = 3'd5
  } verdict_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  payload_byte;
    verdict_t    verdict;
    logic [31:0] reply_address;
    logic [15:0] reply_port;
    logic [15:0] payload_length;
    logic        last;
  } item_t;

  // Up to two result items caused by one input beat, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    item_t      first;
    item_t      second;
  } push_t;

endpackage

### src/iurf_parser.sv
module iurf_parser import iurf_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  packet_byte,
  input  logic        end_of_packet,
  input  logic [15:0] expected_source_port,
  input  logic [15:0] expected_dest_port,
  output push_t       push
);

  localparam logic [OFFSET_BITS-1:0] LIMIT = {OFFSET_BITS{1'b1}};

  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [5:0]  header_bytes, header_bytes_next;
  logic [7:0]  protocol_number, protocol_number_next;
  logic [31:0] source_address, source_address_next;
  logic [15:0] seen_source_port, seen_source_port_next;
  logic [15:0] seen_dest_port, seen_dest_port_next;
  logic [15:0] udp_length, udp_length_next;

  logic                   below_limit;
  logic                   in_udp;
  logic [OFFSET_BITS-1:0] rel;
  logic [15:0]            data_len, data_len_next;
  logic                   ports_ok, ports_ok_next;
  logic                   pay_hit;
  logic [16:0]            rx17, hb17;
  verdict_t               verdict;
  item_t                  pay_item, ver_item;

  always_comb begin
    below_limit           = byte_offset != LIMIT;
    header_bytes_next     = header_bytes;
    protocol_number_next  = protocol_number;
    source_address_next   = source_address;
    seen_source_port_next = seen_source_port;
    seen_dest_port_next   = seen_dest_port;
    udp_length_next       = udp_length;
    pay_hit               = 1'b0;

    data_len = (udp_length >= 16'(UDP_HEADER)) ? udp_length - 16'(UDP_HEADER) : 16'd0;
    ports_ok = (seen_source_port == expected_source_port) &&
               (seen_dest_port == expected_dest_port);
    in_udp   = (header_bytes >= 6'(MIN_HEADER)) &&
               (byte_offset >= OFFSET_BITS'(header_bytes));
    rel      = byte_offset - OFFSET_BITS'(header_bytes);

    if (below_limit) begin
      if (byte_offset == OFFSET_BITS'(0)) begin
        header_bytes_next = {packet_byte[3:0] & IHL_MASK[3:0], 2'b00};
      end else if (byte_offset == OFFSET_BITS'(9)) begin
        protocol_number_next = packet_byte;
      end else if (byte_offset >= OFFSET_BITS'(12) && byte_offset <= OFFSET_BITS'(15)) begin
        source_address_next = {source_address[23:0], packet_byte};
      end

      if (in_udp) begin
        case (rel)
          OFFSET_BITS'(0): seen_source_port_next = {packet_byte, seen_source_port[7:0]};
          OFFSET_BITS'(1): seen_source_port_next = {seen_source_port[15:8], packet_byte};
          OFFSET_BITS'(2): seen_dest_port_next   = {packet_byte, seen_dest_port[7:0]};
          OFFSET_BITS'(3): seen_dest_port_next   = {seen_dest_port[15:8], packet_byte};
          OFFSET_BITS'(4): udp_length_next       = {packet_byte, udp_length[7:0]};
          OFFSET_BITS'(5): udp_length_next       = {udp_length[15:8], packet_byte};
          default: begin
            pay_hit = (rel >= OFFSET_BITS'(UDP_HEADER)) &&
                      (17'(rel) < 17'(UDP_HEADER) + {1'b0, data_len}) &&
                      (protocol_number == PROTO_UDP) && ports_ok;
          end
        endcase
      end
    end

    byte_offset_next = below_limit ? byte_offset + OFFSET_BITS'(1) : byte_offset;
  end

  // The verdict looks at the packet as it stands after this beat.
  always_comb begin
    data_len_next = (udp_length_next >= 16'(UDP_HEADER)) ?
                    udp_length_next - 16'(UDP_HEADER) : 16'd0;
    ports_ok_next = (seen_source_port_next == expected_source_port) &&
                    (seen_dest_port_next == expected_dest_port);
    rx17 = 17'(byte_offset_next);
    hb17 = 17'(header_bytes_next);
    if (rx17 < 17'(MIN_HEADER)) begin
      verdict = VERDICT_SHORT;
    end else if (header_bytes_next < 6'(MIN_HEADER) || rx17 < hb17 + 17'(UDP_HEADER)) begin
      verdict = VERDICT_BAD_IHL;
    end else if (protocol_number_next != PROTO_UDP) begin
      verdict = VERDICT_NOT_UDP;
    end else if (!ports_ok_next) begin
      verdict = VERDICT_PORT_MISS;
    end else if (rx17 < hb17 + 17'(UDP_HEADER) + {1'b0, data_len_next}) begin
      verdict = VERDICT_TRUNCATED;
    end else begin
      verdict = VERDICT_ACCEPTED;
    end
  end

  always_comb begin
    pay_item              = '0;
    pay_item.kind         = KIND_PAYLOAD;
    pay_item.payload_byte = packet_byte;

    ver_item                = '0;
    ver_item.kind           = KIND_VERDICT;
    ver_item.verdict        = verdict;
    ver_item.reply_address  = source_address_next;
    ver_item.reply_port     = seen_source_port_next;
    ver_item.payload_length = data_len_next;
    ver_item.last           = 1'b1;

    push = '0;
    if (accept) begin
      push.count  = 2'(pay_hit) + 2'(end_of_packet);
      push.first  = pay_hit ? pay_item : ver_item;
      push.second = ver_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_packet)) begin
      byte_offset      <= '0;
      header_bytes     <= '0;
      protocol_number  <= '0;
      source_address   <= '0;
      seen_source_port <= '0;
      seen_dest_port   <= '0;
      udp_length       <= '0;
    end else if (accept) begin
      byte_offset      <= byte_offset_next;
      header_bytes     <= header_bytes_next;
      protocol_number  <= protocol_number_next;
      source_address   <= source_address_next;
      seen_source_port <= seen_source_port_next;
      seen_dest_port   <= seen_dest_port_next;
      udp_length       <= udp_length_next;
    end
  end

endmodule

### src/iurf_fifo.sv
module iurf_fifo import iurf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t head
);

  item_t      entries [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 3'd0;
  assign head      = entries[rd_ptr];
  // Keep space for the two items one beat can cause.
  assign room      = count <= 3'd2;

  always_comb begin
    count_next = count + 3'(push.count) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count_next;
    end
  end

endmodule

### src/ipv4_udp_reply_filter.sv
// IPv4/UDP reply filter.
// Input channel: one captured packet byte per beat (in_valid/in_ready), with
// end_of_packet on the final byte. Header fields are decoded on the fly.
// Output channel (out_valid/out_ready): payload items for UDP payload bytes
// whose ports match the configured pair, and one verdict item per packet
// with last set. Payload items count only if the verdict is accepted.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 sets
// the expected source port, index 1 the expected destination port; other
// indexes are ignored. Write only between packets.
// Each result is written into the result queue and leaves it from its head.
// Throughput: one input beat per cycle while the four-entry result queue has room;
// an end byte that is also a payload byte yields two items, which drain at
// one item per cycle while out_ready is high.
// Reset clears the decoder state, the configured ports and the queue.
// When the receiver stalls, the queue fills and in_ready drops once fewer
// than two entries are free.
module ipv4_udp_reply_filter import iurf_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  packet_byte,
  input  logic        end_of_packet,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  verdict,
  output logic [31:0] reply_address,
  output logic [15:0] reply_port,
  output logic [15:0] payload_length,
  output logic        last
);

  logic [15:0] expected_source_port;
  logic [15:0] expected_dest_port;
  logic        accept;
  logic        room;
  push_t       push;
  item_t       head;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign accept    = in_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_source_port <= '0;
      expected_dest_port   <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_EXPECTED_SOURCE_PORT) begin
        expected_source_port <= cfg_data;
      end else if (cfg_index == CFG_EXPECTED_DEST_PORT) begin
        expected_dest_port <= cfg_data;
      end
    end
  end

  iurf_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk                  (clk),
    .rst                  (rst),
    .accept               (accept),
    .packet_byte          (packet_byte),
    .end_of_packet        (end_of_packet),
    .expected_source_port (expected_source_port),
    .expected_dest_port   (expected_dest_port),
    .push                 (push)
  );

  iurf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign item_kind      = head.kind;
  assign payload_byte   = head.payload_byte;
  assign verdict        = head.verdict;
  assign reply_address  = head.reply_address;
  assign reply_port     = head.reply_port;
  assign payload_length = head.payload_length;
  assign last           = head.last;

endmodule
